// ----- rtl/core/mgr_pkg.sv -----
// Shared types and constants of the mouse gesture recognizer.
package mgr_pkg;

    // Request codes of the input beat
    localparam logic [1:0] REQ_PRESS   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_MOVE    = 2'd2;
    localparam logic [1:0] REQ_SCROLL  = 2'd3;

    // Event codes of the result beat
    localparam logic [3:0] EV_PRESS   = 4'd0;
    localparam logic [3:0] EV_RELEASE = 4'd1;
    localparam logic [3:0] EV_CLICK   = 4'd2;
    localparam logic [3:0] EV_CHORD   = 4'd3;
    localparam logic [3:0] EV_DRAG    = 4'd4;
    localparam logic [3:0] EV_LEFT    = 4'd5;
    localparam logic [3:0] EV_POINT   = 4'd9;
    localparam logic [3:0] EV_SCROLL  = 4'd10;

    // Register indexes
    localparam logic [2:0] CFG_DRAG_RX  = 3'd0;
    localparam logic [2:0] CFG_DRAG_RY  = 3'd1;
    localparam logic [2:0] CFG_CLICK_RX = 3'd2;
    localparam logic [2:0] CFG_CLICK_RY = 3'd3;
    localparam logic [2:0] CFG_LIMIT_X  = 3'd4;
    localparam logic [2:0] CFG_LIMIT_Y  = 3'd5;
    localparam logic [2:0] CFG_MASK     = 3'd6;

    localparam int RAD_W  = 12;
    localparam int LIM_W  = 14;
    localparam int MASK_W = 29;

    // Per-button enable offsets: button*8 + offset
    localparam logic [2:0] EN_DRAG    = 3'd0;
    localparam logic [2:0] EN_LEFT    = 3'd1;
    localparam logic [2:0] EN_CLICK   = 3'd5;
    localparam logic [2:0] EN_PRESS   = 3'd6;
    localparam logic [2:0] EN_RELEASE = 3'd7;

    // Global enable bits
    localparam int MB_POINT   = 24;
    localparam int MB_CHORD_L = 25;
    localparam int MB_CHORD_R = 26;
    localparam int MB_SCROLL0 = 27;
    localparam int MB_SCROLL1 = 28;

    localparam int MAX_RESULTS = 6;

    // One result written into the result buffer
    typedef struct packed {
        logic       en;
        logic [3:0] kind;
        logic [1:0] btn;
    } emit_t;

    // Flags of the distance unit
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic x_lt;
        logic y_lt;
        logic x_gt;
        logic y_gt;
        logic ax_ge_ay;
        logic ay_ge_ax;
    } dist_t;

endpackage

// ----- rtl/core/mouse_gesture_recognizer.sv -----
// Top level of the mouse gesture recognizer: sequencer, button state and registers.
//
// Takes one pointer beat (press, release, move or scroll) at a time and turns it into
// zero to six result beats: press, release, click, chord, drag, one-shot left/right/
// up/down motion, point and scroll, each gated by its bit in handler_mask. A sequencer
// walks the buttons one per cycle through a single shared distance unit (subtract,
// absolute value, radius compare). Press, scroll and a release outside the click
// radius pass S_PRESS, S_SCROLL or S_REL; an unknown button goes right to S_DONE. A
// release inside the click radius goes on through S_RALL and S_RFIN; a move through
// S_SCAN, S_DRAG and S_POINT, plus S_RALL if the cursor leaves a click radius. The
// collected results drain one per cycle as m_ready allows, is_last marking the final
// one. s_ready stays low from accept until the last result beat is taken. Registers
// must be written through cfg_wr_* while idle, which the block does not enforce; zero
// written to a radius register is ignored and buttons 3 and up carry no enable bits.
module mouse_gesture_recognizer #(
    parameter int BUTTONS    = 3,
    parameter int COORD_BITS = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [1:0]            s_button,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic                  s_scroll_dir,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_event_kind,
    output logic [1:0]            m_event_button,
    output logic [COORD_BITS-1:0] m_start_x,
    output logic [COORD_BITS-1:0] m_start_y,
    output logic [COORD_BITS-1:0] m_cur_x,
    output logic [COORD_BITS-1:0] m_cur_y,
    output logic                  m_is_last,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_wr_index,
    input  logic [28:0]           cfg_wr_data
);
    localparam int IW     = $clog2(BUTTONS);
    localparam bit HAS_B2 = BUTTONS > 2;
    localparam int PW     = (COORD_BITS > mgr_pkg::LIM_W) ? COORD_BITS : mgr_pkg::LIM_W;
    localparam int RW     = mgr_pkg::RAD_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PRESS  = 4'd1;
    localparam logic [3:0] S_SCROLL = 4'd2;
    localparam logic [3:0] S_REL    = 4'd3;
    localparam logic [3:0] S_RALL   = 4'd4;
    localparam logic [3:0] S_RFIN   = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_DRAG   = 4'd7;
    localparam logic [3:0] S_POINT  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    // What closes a release once all buttons are let go
    localparam logic [1:0] MODE_CLICK   = 2'd0;
    localparam logic [1:0] MODE_CHORD_L = 2'd1;
    localparam logic [1:0] MODE_CHORD_R = 2'd2;

    // Registers
    logic [RW-1:0]               drx_reg, dry_reg, crx_reg, cry_reg;
    logic [mgr_pkg::LIM_W-1:0]   plx_reg, ply_reg;
    logic [mgr_pkg::MASK_W-1:0]  hm_reg;

    // Button state
    logic [BUTTONS-1:0]    sv_reg, sv_next;
    logic [BUTTONS-1:0]    held_reg, held_next;
    logic [COORD_BITS-1:0] spx_reg [BUTTONS];
    logic [COORD_BITS-1:0] spy_reg [BUTTONS];
    logic                  sp_wr;
    logic [3:0]            mo_reg, mo_next;

    // Sequencer
    logic [3:0]            state_reg, state_next;
    logic [IW-1:0]         b_reg, b_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [1:0]            mode_reg, mode_next;
    logic                  any_reg, any_next;
    logic                  ra_move_reg, ra_move_next;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic                  dir_reg;
    logic                  accept;
    logic                  done;
    logic                  busy;

    // Shared unit hookup
    logic [IW-1:0]         sel;
    logic                  use_drag;
    logic [RW-1:0]         rx, ry;
    mgr_pkg::dist_t        dflags;

    // Emit path
    mgr_pkg::emit_t        em;
    logic                  em_en;
    logic [3:0]            em_kind;
    logic [1:0]            em_btn;
    logic [COORD_BITS-1:0] em_sx, em_sy, em_cx, em_cy;

    function automatic logic btn_en(input logic [IW-1:0] s, input logic [2:0] k,
                                    input logic [mgr_pkg::MASK_W-1:0] mask);
        logic [3:0] sw;
        logic [4:0] bit_i;
        sw    = 4'(s);
        bit_i = {sw[1:0], k};
        return (sw < 4'd3) && mask[bit_i];
    endfunction

    assign s_ready = (state_reg == S_IDLE) && !busy;
    assign accept  = s_valid && s_ready;
    assign done    = state_reg == S_DONE;

    assign rx = use_drag ? drx_reg : crx_reg;
    assign ry = use_drag ? dry_reg : cry_reg;

    assign em = {em_en, em_kind, em_btn};

    mgr_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .a_x   (x_reg),
        .a_y   (y_reg),
        .s_x   (spx_reg[sel]),
        .s_y   (spy_reg[sel]),
        .r_x   (rx),
        .r_y   (ry),
        .flags (dflags)
    );

    // Register writes; zero radius writes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drx_reg <= RW'(16);
            dry_reg <= RW'(16);
            crx_reg <= RW'(4);
            cry_reg <= RW'(4);
            plx_reg <= '1;
            ply_reg <= '1;
            hm_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                mgr_pkg::CFG_DRAG_RX: begin
                    if (cfg_wr_data[RW-1:0] != '0) drx_reg <= cfg_wr_data[RW-1:0];
                end
                mgr_pkg::CFG_DRAG_RY: begin
                    if (cfg_wr_data[RW-1:0] != '0) dry_reg <= cfg_wr_data[RW-1:0];
                end
                mgr_pkg::CFG_CLICK_RX: begin
                    if (cfg_wr_data[RW-1:0] != '0) crx_reg <= cfg_wr_data[RW-1:0];
                end
                mgr_pkg::CFG_CLICK_RY: begin
                    if (cfg_wr_data[RW-1:0] != '0) cry_reg <= cfg_wr_data[RW-1:0];
                end
                mgr_pkg::CFG_LIMIT_X: plx_reg <= cfg_wr_data[mgr_pkg::LIM_W-1:0];
                mgr_pkg::CFG_LIMIT_Y: ply_reg <= cfg_wr_data[mgr_pkg::LIM_W-1:0];
                mgr_pkg::CFG_MASK:    hm_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [3:0] m;
        logic [3:0] cond;
        logic       fired;
        logic       in_click;

        state_next   = state_reg;
        b_next       = b_reg;
        i_next       = i_reg;
        mode_next    = mode_reg;
        any_next     = any_reg;
        ra_move_next = ra_move_reg;
        sv_next      = sv_reg;
        held_next    = held_reg;
        mo_next      = mo_reg;
        sp_wr        = 1'b0;
        sel          = b_reg;
        use_drag     = 1'b0;
        em_en        = 1'b0;
        em_kind      = mgr_pkg::EV_PRESS;
        m            = mo_reg;
        cond         = '0;
        fired        = 1'b0;
        in_click     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    b_next   = IW'(s_button);
                    i_next   = '0;
                    any_next = 1'b0;
                    case (s_req_type)
                        mgr_pkg::REQ_PRESS: begin
                            state_next = ({2'b00, s_button} < 4'(BUTTONS)) ? S_PRESS : S_DONE;
                        end
                        mgr_pkg::REQ_RELEASE: begin
                            state_next = ({2'b00, s_button} < 4'(BUTTONS)) ? S_REL : S_DONE;
                        end
                        mgr_pkg::REQ_MOVE: state_next = S_SCAN;
                        default:           state_next = S_SCROLL;
                    endcase
                end
            end
            S_PRESS: begin
                // Overwrite the start point and rearm the motions
                sp_wr          = 1'b1;
                sv_next[b_reg] = 1'b1;
                held_next[b_reg] = 1'b1;
                mo_next        = '0;
                em_en          = btn_en(b_reg, mgr_pkg::EN_PRESS, hm_reg);
                em_kind        = mgr_pkg::EV_PRESS;
                state_next     = S_DONE;
            end
            S_SCROLL: begin
                em_en      = dir_reg ? hm_reg[mgr_pkg::MB_SCROLL1] : hm_reg[mgr_pkg::MB_SCROLL0];
                em_kind    = mgr_pkg::EV_SCROLL;
                state_next = S_DONE;
            end
            S_REL: begin
                if (held_reg[b_reg]) begin
                    held_next[b_reg] = 1'b0;
                    em_en   = btn_en(b_reg, mgr_pkg::EN_RELEASE, hm_reg);
                    em_kind = mgr_pkg::EV_RELEASE;
                end
                in_click = sv_reg[b_reg] && !dflags.x_gt && !dflags.y_gt;
                if (in_click) begin
                    if (HAS_B2 && (b_reg == IW'(2)) && sv_reg[0]) begin
                        mode_next = MODE_CHORD_L;
                    end else if (HAS_B2 && (b_reg == '0) && sv_reg[IW'(2)]) begin
                        mode_next = MODE_CHORD_R;
                    end else begin
                        mode_next = MODE_CLICK;
                    end
                    i_next       = '0;
                    ra_move_next = 1'b0;
                    state_next   = S_RALL;
                end else begin
                    sv_next[b_reg] = 1'b0;
                    state_next     = S_DONE;
                end
            end
            S_RALL: begin
                // Let go of every held button, one per cycle
                sel = i_reg;
                if (held_reg[i_reg]) begin
                    held_next[i_reg] = 1'b0;
                    em_en   = btn_en(i_reg, mgr_pkg::EN_RELEASE, hm_reg);
                    em_kind = mgr_pkg::EV_RELEASE;
                end
                if (i_reg == IW'(BUTTONS - 1)) begin
                    i_next     = '0;
                    state_next = ra_move_reg ? S_DRAG : S_RFIN;
                end else begin
                    i_next = i_reg + IW'(1);
                end
            end
            S_RFIN: begin
                em_kind = mgr_pkg::EV_CLICK;
                case (mode_reg)
                    MODE_CHORD_L: begin
                        sel        = '0;
                        em_en      = hm_reg[mgr_pkg::MB_CHORD_L];
                        em_kind    = mgr_pkg::EV_CHORD;
                        sv_next[0] = 1'b0;
                    end
                    MODE_CHORD_R: begin
                        sel             = IW'(2);
                        em_en           = hm_reg[mgr_pkg::MB_CHORD_R];
                        em_kind         = mgr_pkg::EV_CHORD;
                        sv_next[IW'(2)] = 1'b0;
                    end
                    default: begin
                        em_en = btn_en(b_reg, mgr_pkg::EN_CLICK, hm_reg);
                    end
                endcase
                sv_next[b_reg] = 1'b0;
                state_next     = S_DONE;
            end
            S_SCAN: begin
                // Any started button outside its click radius lets all go
                sel = i_reg;
                if (sv_reg[i_reg] && !(dflags.x_lt && dflags.y_lt)) begin
                    i_next       = '0;
                    ra_move_next = 1'b1;
                    state_next   = S_RALL;
                end else if (i_reg == IW'(BUTTONS - 1)) begin
                    i_next     = '0;
                    state_next = S_DRAG;
                end else begin
                    i_next = i_reg + IW'(1);
                end
            end
            S_DRAG: begin
                sel      = i_reg;
                use_drag = 1'b1;
                if (sv_reg[i_reg]) begin
                    any_next = 1'b1;
                    if (btn_en(i_reg, mgr_pkg::EN_DRAG, hm_reg)) begin
                        em_en   = 1'b1;
                        em_kind = mgr_pkg::EV_DRAG;
                    end else begin
                        // Rearm inside the drag radius, then try left, right, up, down
                        if (dflags.x_lt && dflags.y_lt) m = '0;
                        cond[0] = dflags.ax_ge_ay && dflags.x_neg && !dflags.x_lt;
                        cond[1] = dflags.ax_ge_ay && !dflags.x_neg && !dflags.x_lt;
                        cond[2] = dflags.ay_ge_ax && dflags.y_neg && !dflags.y_lt;
                        cond[3] = dflags.ay_ge_ax && !dflags.y_neg && !dflags.y_lt;
                        for (int k = 0; k < 4; k++) begin
                            if (!fired && cond[k] && !m[k]) begin
                                m = 4'b0001 << k;
                                if (btn_en(i_reg, mgr_pkg::EN_LEFT + 3'(k), hm_reg)) begin
                                    em_en   = 1'b1;
                                    em_kind = mgr_pkg::EV_LEFT + 4'(k);
                                    fired   = 1'b1;
                                end
                            end
                        end
                        mo_next = m;
                    end
                end
                if (i_reg == IW'(BUTTONS - 1)) begin
                    state_next = S_POINT;
                end else begin
                    i_next = i_reg + IW'(1);
                end
            end
            S_POINT: begin
                em_en = !any_reg && hm_reg[mgr_pkg::MB_POINT]
                        && (PW'(x_reg) < PW'(plx_reg)) && (PW'(y_reg) < PW'(ply_reg));
                em_kind    = mgr_pkg::EV_POINT;
                state_next = S_DONE;
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result fields: start point of the selected button, cursor of the request; press, scroll and point set their own
    always_comb begin
        em_btn = 2'(sel);
        em_sx  = sv_reg[sel] ? spx_reg[sel] : '0;
        em_sy  = sv_reg[sel] ? spy_reg[sel] : '0;
        em_cx  = x_reg;
        em_cy  = y_reg;
        case (state_reg)
            S_PRESS: begin
                em_sx = x_reg;
                em_sy = y_reg;
            end
            S_SCROLL: begin
                em_btn = {1'b0, dir_reg};
                em_sx  = '0;
                em_sy  = '0;
                em_cx  = '0;
                em_cy  = '0;
            end
            S_POINT: begin
                em_btn = '0;
                em_sx  = '0;
                em_sy  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            b_reg       <= '0;
            i_reg       <= '0;
            mode_reg    <= MODE_CLICK;
            any_reg     <= 1'b0;
            ra_move_reg <= 1'b0;
            sv_reg      <= '0;
            held_reg    <= '0;
            mo_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            b_reg       <= b_next;
            i_reg       <= i_next;
            mode_reg    <= mode_next;
            any_reg     <= any_next;
            ra_move_reg <= ra_move_next;
            sv_reg      <= sv_next;
            held_reg    <= held_next;
            mo_reg      <= mo_next;
        end
    end

    // Start points: cleared by reset, since they show up in results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < BUTTONS; n++) begin
                spx_reg[n] <= '0;
                spy_reg[n] <= '0;
            end
        end else if (sp_wr) begin
            spx_reg[b_reg] <= x_reg;
            spy_reg[b_reg] <= y_reg;
        end
    end

    // Hold the request payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= s_pos_x;
            y_reg   <= s_pos_y;
            dir_reg <= s_scroll_dir;
        end
    end

    mgr_rbuf #(
        .COORD_BITS (COORD_BITS)
    ) u_rbuf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .wr             (em),
        .wr_sx          (em_sx),
        .wr_sy          (em_sy),
        .wr_cx          (em_cx),
        .wr_cy          (em_cy),
        .done           (done),
        .busy           (busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_event_button (m_event_button),
        .m_start_x      (m_start_x),
        .m_start_y      (m_start_y),
        .m_cur_x        (m_cur_x),
        .m_cur_y        (m_cur_y),
        .m_is_last      (m_is_last)
    );

    // Never take a request while results still drain
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while results drain");

    // A held button always has a start point
    a_held_started: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg & ~sv_reg) == '0)
        else $error("held button without start point");

    // At most one motion direction is latched
    a_motion_once: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(mo_reg))
        else $error("more than one motion latched");

endmodule

// ----- rtl/core/mgr_dist.sv -----
// Shared distance unit: absolute offsets from a start point and radius compares.
module mgr_dist #(
    parameter int COORD_BITS = 14
) (
    input  logic [COORD_BITS-1:0]     a_x,
    input  logic [COORD_BITS-1:0]     a_y,
    input  logic [COORD_BITS-1:0]     s_x,
    input  logic [COORD_BITS-1:0]     s_y,
    input  logic [mgr_pkg::RAD_W-1:0] r_x,
    input  logic [mgr_pkg::RAD_W-1:0] r_y,
    output mgr_pkg::dist_t            flags
);
    localparam int DW = COORD_BITS + 1;
    localparam int CW = (COORD_BITS > mgr_pkg::RAD_W) ? COORD_BITS : mgr_pkg::RAD_W;

    logic [DW-1:0]         dx, dy;
    logic [COORD_BITS-1:0] ax, ay;
    logic [CW-1:0]         ax_e, ay_e, rx_e, ry_e;

    always_comb begin
        dx = {1'b0, a_x} - {1'b0, s_x};
        dy = {1'b0, a_y} - {1'b0, s_y};
        ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        ax_e = CW'(ax);
        ay_e = CW'(ay);
        rx_e = CW'(r_x);
        ry_e = CW'(r_y);
        flags.x_neg    = dx[COORD_BITS];
        flags.y_neg    = dy[COORD_BITS];
        flags.x_lt     = ax_e < rx_e;
        flags.y_lt     = ay_e < ry_e;
        flags.x_gt     = ax_e > rx_e;
        flags.y_gt     = ay_e > ry_e;
        flags.ax_ge_ay = ax >= ay;
        flags.ay_ge_ax = ay >= ax;
    end
endmodule

// ----- rtl/core/mgr_rbuf.sv -----
// Result buffer: collects the results of one request, then drains them in order.
module mgr_rbuf #(
    parameter int COORD_BITS = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mgr_pkg::emit_t        wr,
    input  logic [COORD_BITS-1:0] wr_sx,
    input  logic [COORD_BITS-1:0] wr_sy,
    input  logic [COORD_BITS-1:0] wr_cx,
    input  logic [COORD_BITS-1:0] wr_cy,
    input  logic                  done,
    output logic                  busy,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_event_kind,
    output logic [1:0]            m_event_button,
    output logic [COORD_BITS-1:0] m_start_x,
    output logic [COORD_BITS-1:0] m_start_y,
    output logic [COORD_BITS-1:0] m_cur_x,
    output logic [COORD_BITS-1:0] m_cur_y,
    output logic                  m_is_last
);
    localparam int N  = mgr_pkg::MAX_RESULTS;
    localparam int CNTW = $clog2(N + 1);
    localparam int IXW  = $clog2(N);

    logic [3:0]            kind_mem [N];
    logic [1:0]            btn_mem  [N];
    logic [COORD_BITS-1:0] sx_mem   [N];
    logic [COORD_BITS-1:0] sy_mem   [N];
    logic [COORD_BITS-1:0] cx_mem   [N];
    logic [COORD_BITS-1:0] cy_mem   [N];

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [IXW-1:0]  rd_reg, rd_next;
    logic            drain_reg, drain_next;
    logic            last;
    logic            push;

    assign push = wr.en && (cnt_reg < CNTW'(N));
    assign last = CNTW'(rd_reg) == (cnt_reg - CNTW'(1));

    always_comb begin
        cnt_next   = cnt_reg;
        rd_next    = rd_reg;
        drain_next = drain_reg;
        if (push) begin
            cnt_next = cnt_reg + CNTW'(1);
        end
        if (done && (cnt_reg != '0)) begin
            drain_next = 1'b1;
            rd_next    = '0;
        end
        if (drain_reg && m_ready) begin
            if (last) begin
                drain_next = 1'b0;
                cnt_next   = '0;
            end else begin
                rd_next = rd_reg + IXW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            rd_reg    <= '0;
            drain_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            rd_reg    <= rd_next;
            drain_reg <= drain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            kind_mem[cnt_reg[IXW-1:0]] <= wr.kind;
            btn_mem[cnt_reg[IXW-1:0]]  <= wr.btn;
            sx_mem[cnt_reg[IXW-1:0]]   <= wr_sx;
            sy_mem[cnt_reg[IXW-1:0]]   <= wr_sy;
            cx_mem[cnt_reg[IXW-1:0]]   <= wr_cx;
            cy_mem[cnt_reg[IXW-1:0]]   <= wr_cy;
        end
    end

    assign busy           = drain_reg;
    assign m_valid        = drain_reg;
    assign m_event_kind   = kind_mem[rd_reg];
    assign m_event_button = btn_mem[rd_reg];
    assign m_start_x      = sx_mem[rd_reg];
    assign m_start_y      = sy_mem[rd_reg];
    assign m_cur_x        = cx_mem[rd_reg];
    assign m_cur_y        = cy_mem[rd_reg];
    assign m_is_last      = last;
endmodule

// ----- bench/mouse_gesture_recognizer_test.sv -----
// Self-checking testbench of the mouse gesture recognizer: stimulus, predictor, scoreboard.
module mouse_gesture_recognizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mgr_pkg::*;

    localparam int NBTN = 3;
    localparam int CMAX = 16383;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  btn;
        logic [13:0] x;
        logic [13:0] y;
        logic        dir;
    } pointer_req_t;

    typedef struct {
        logic [3:0]  kind;
        logic [1:0]  btn;
        logic [13:0] sx;
        logic [13:0] sy;
        logic [13:0] cx;
        logic [13:0] cy;
        logic        last;
    } gesture_ev_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [1:0]  s_button;
    logic [13:0] s_pos_x;
    logic [13:0] s_pos_y;
    logic        s_scroll_dir;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_event_kind;
    logic [1:0]  m_event_button;
    logic [13:0] m_start_x;
    logic [13:0] m_start_y;
    logic [13:0] m_cur_x;
    logic [13:0] m_cur_y;
    logic        m_is_last;
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_index;
    logic [28:0] cfg_wr_data;

    mouse_gesture_recognizer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_button      (s_button),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_scroll_dir  (s_scroll_dir),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_event_button(m_event_button),
        .m_start_x     (m_start_x),
        .m_start_y     (m_start_y),
        .m_cur_x       (m_cur_x),
        .m_cur_y       (m_cur_y),
        .m_is_last     (m_is_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Mirror of the block's registers and gesture state
    int unsigned drag_rx, drag_ry, click_rx, click_ry, limit_x, limit_y;
    logic [28:0] ev_mask;
    bit          has_start [NBTN];
    int          start_x   [NBTN];
    int          start_y   [NBTN];
    bit          is_held   [NBTN];
    logic [3:0]  motion_done;

    pointer_req_t pending_reqs[$];
    gesture_ev_t  step_events[$];
    gesture_ev_t  expected_events[$];
    pointer_req_t on_bus;

    int     queued_cnt;
    int     accepted_cnt;
    int     event_cnt;
    int     error_cnt;
    longint cycle_cnt;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit mask_on(int bit_no);
        return bit_no < MASK_W && ev_mask[bit_no];
    endfunction

    function automatic bit button_on(int b, int offset);
        return b < 3 && mask_on(b * 8 + offset);
    endfunction

    function automatic int abs_diff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Collect one event; the block caps a step at six
    function automatic void add_event(logic [3:0] kind, int b, int sx, int sy,
                                      int cx, int cy);
        gesture_ev_t ev;
        if (step_events.size() >= MAX_RESULTS) return;
        ev.kind = kind;
        ev.btn  = b[1:0];
        ev.sx   = sx[13:0];
        ev.sy   = sy[13:0];
        ev.cx   = cx[13:0];
        ev.cy   = cy[13:0];
        ev.last = 1'b0;
        step_events.push_back(ev);
    endfunction

    function automatic void add_button_event(logic [3:0] kind, int b, int x, int y);
        add_event(kind, b, has_start[b] ? start_x[b] : 0, has_start[b] ? start_y[b] : 0,
                  x, y);
    endfunction

    function automatic void drop_hold(int b, int x, int y);
        if (!is_held[b]) return;
        is_held[b] = 1'b0;
        if (button_on(b, EN_RELEASE)) add_button_event(EV_RELEASE, b, x, y);
    endfunction

    function automatic void drop_all_holds(int x, int y);
        for (int i = 0; i < NBTN; i++) drop_hold(i, x, y);
    endfunction

    // One-shot motion m: 0 left, 1 right, 2 up, 3 down; note the flag set replaces the rest
    function automatic bit fire_motion(int b, int m, bit cond, int x, int y);
        if (!cond || motion_done[m]) return 1'b0;
        motion_done = 4'b0001 << m;
        if (button_on(b, EN_LEFT + m)) begin
            add_button_event(4'(EV_LEFT + m), b, x, y);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void track_drag(int b, int x, int y);
        int dx, dy, ax, ay, rx, ry;
        dx = x - start_x[b];
        dy = y - start_y[b];
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        rx = drag_rx;
        ry = drag_ry;
        if (button_on(b, EN_DRAG)) begin
            add_button_event(EV_DRAG, b, x, y);
            return;
        end
        if (ax < rx && ay < ry) motion_done = '0;
        if (fire_motion(b, 0, ax >= ay && dx <= -rx, x, y)) return;
        if (fire_motion(b, 1, ax >= ay && dx >= rx, x, y)) return;
        if (fire_motion(b, 2, ay >= ax && dy <= -ry, x, y)) return;
        void'(fire_motion(b, 3, ay >= ax && dy >= ry, x, y));
    endfunction

    function automatic void on_press(int b, int x, int y);
        start_x[b]   = x;
        start_y[b]   = y;
        has_start[b] = 1'b1;
        motion_done  = '0;
        is_held[b]   = 1'b1;
        if (button_on(b, EN_PRESS)) add_button_event(EV_PRESS, b, x, y);
    endfunction

    function automatic void on_release(int b, int x, int y);
        drop_hold(b, x, y);
        if (has_start[b] && abs_diff(start_x[b], x) <= int'(click_rx)
                && abs_diff(start_y[b], y) <= int'(click_ry)) begin
            drop_all_holds(x, y);
            if (b == 2 && has_start[0]) begin
                if (mask_on(MB_CHORD_L)) add_button_event(EV_CHORD, 0, x, y);
                has_start[0] = 1'b0;
            end else if (b == 0 && has_start[2]) begin
                if (mask_on(MB_CHORD_R)) add_button_event(EV_CHORD, 2, x, y);
                has_start[2] = 1'b0;
            end else if (button_on(b, EN_CLICK)) begin
                add_button_event(EV_CLICK, b, x, y);
            end
        end
        has_start[b] = 1'b0;
    endfunction

    function automatic void on_move(int x, int y);
        bit left_radius;
        bit any_start;
        left_radius = 1'b0;
        any_start   = 1'b0;
        for (int i = 0; i < NBTN; i++) begin
            if (has_start[i] && !left_radius && !(abs_diff(x, start_x[i]) < int'(click_rx)
                    && abs_diff(y, start_y[i]) < int'(click_ry)))
                left_radius = 1'b1;
        end
        if (left_radius) drop_all_holds(x, y);
        for (int i = 0; i < NBTN; i++) begin
            if (has_start[i]) begin
                track_drag(i, x, y);
                any_start = 1'b1;
            end
        end
        if (!any_start && x < int'(limit_x) && y < int'(limit_y) && mask_on(MB_POINT))
            add_event(EV_POINT, 0, 0, 0, x, y);
    endfunction

    // Work out the events of one accepted request and queue them for checking
    function automatic void predict_events(pointer_req_t r);
        step_events.delete();
        case (r.kind)
            REQ_PRESS:   if (r.btn < NBTN) on_press(r.btn, r.x, r.y);
            REQ_RELEASE: if (r.btn < NBTN) on_release(r.btn, r.x, r.y);
            REQ_MOVE:    on_move(r.x, r.y);
            default:     if (mask_on(MB_SCROLL0 + r.dir)) add_event(EV_SCROLL, r.dir, 0, 0, 0, 0);
        endcase
        if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i]) expected_events.push_back(step_events[i]);
    endfunction

    function automatic void mirror_register(logic [2:0] index, logic [28:0] value);
        case (index)
            CFG_DRAG_RX:  if (value[11:0] != 0) drag_rx  = value[11:0];
            CFG_DRAG_RY:  if (value[11:0] != 0) drag_ry  = value[11:0];
            CFG_CLICK_RX: if (value[11:0] != 0) click_rx = value[11:0];
            CFG_CLICK_RY: if (value[11:0] != 0) click_ry = value[11:0];
            CFG_LIMIT_X:  limit_x = value[13:0];
            CFG_LIMIT_Y:  limit_y = value[13:0];
            CFG_MASK:     ev_mask = value;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch on event %0d: %s", $realtime, event_cnt, what);
        error_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and idling
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    // Pause with a chance of 8 in 100, except for a calm stretch in every window
    function automatic bit take_pause();
        if (cycle_cnt % 5000 < 1500) return 1'b0;
        return $urandom_range(99) < 8;
    endfunction

    // ------------------------------------------------------------------
    // Driver: predict on each accepted beat, then load the next pending request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_events(on_bus);
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && !take_pause()) begin
                    on_bus       = pending_reqs.pop_front();
                    s_valid      <= 1'b1;
                    s_req_type   <= on_bus.kind;
                    s_button     <= on_bus.btn;
                    s_pos_x      <= on_bus.x;
                    s_pos_y      <= on_bus.y;
                    s_scroll_dir <= on_bus.dir;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every result beat against the oldest expected event
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat kind %0d", m_event_kind));
                end else begin
                    gesture_ev_t e;
                    e = expected_events.pop_front();
                    if (m_event_kind !== e.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", m_event_kind, e.kind));
                    if (m_event_button !== e.btn)
                        report_mismatch($sformatf("button %0d, want %0d", m_event_button, e.btn));
                    if (m_start_x !== e.sx || m_start_y !== e.sy)
                        report_mismatch($sformatf("start %0d,%0d, want %0d,%0d",
                                        m_start_x, m_start_y, e.sx, e.sy));
                    if (m_cur_x !== e.cx || m_cur_y !== e.cy)
                        report_mismatch($sformatf("cursor %0d,%0d, want %0d,%0d",
                                        m_cur_x, m_cur_y, e.cx, e.cy));
                    if (m_is_last !== e.last)
                        report_mismatch($sformatf("is_last %0b, want %0b", m_is_last, e.last));
                end
                event_cnt++;
            end
            m_ready <= !take_pause();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_req(logic [1:0] kind, int b, int x, int y, bit dir);
        pointer_req_t r;
        r.kind = kind;
        r.btn  = b[1:0];
        r.x    = (x < 0) ? 14'd0 : (x > CMAX) ? 14'(CMAX) : x[13:0];
        r.y    = (y < 0) ? 14'd0 : (y > CMAX) ? 14'(CMAX) : y[13:0];
        r.dir  = dir;
        pending_reqs.push_back(r);
        queued_cnt++;
    endtask

    // Hold until all requests are taken and every event has drained, then let it settle
    task automatic drain();
        while (queued_cnt != accepted_cnt || expected_events.size() > 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_register(logic [2:0] index, logic [28:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        mirror_register(index, value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(int drx, int dry, int crx, int cry, int lx, int ly,
                             logic [28:0] mask);
        drain();
        write_register(CFG_DRAG_RX, 29'(drx));
        write_register(CFG_DRAG_RY, 29'(dry));
        write_register(CFG_CLICK_RX, 29'(crx));
        write_register(CFG_CLICK_RY, 29'(cry));
        write_register(CFG_LIMIT_X, 29'(lx));
        write_register(CFG_LIMIT_Y, 29'(ly));
        write_register(CFG_MASK, mask);
    endtask

    // Offset around a point: mostly near, sometimes past the radii, rarely anywhere
    function automatic int jitter(int span);
        case ($urandom_range(3))
            0, 1: return $urandom_range(2 * 4 + 1) - 4;
            2:    return $urandom_range(2 * span) - span;
            default: return $urandom_range(CMAX) - CMAX / 2;
        endcase
    endfunction

    // A well-formed gesture: press, moves around the start, maybe a second button, release
    task automatic queue_gesture(int span);
        int b, b2, x0, y0;
        b  = $urandom_range(2);
        b2 = $urandom_range(2);
        x0 = $urandom_range(CMAX);
        y0 = $urandom_range(CMAX);
        queue_req(REQ_PRESS, b, x0, y0, 1'b0);
        if ($urandom_range(2) == 0) queue_req(REQ_PRESS, b2, x0 + jitter(span), y0 + jitter(span), 1'b0);
        repeat ($urandom_range(3)) queue_req(REQ_MOVE, 0, x0 + jitter(span), y0 + jitter(span), 1'b0);
        queue_req(REQ_RELEASE, b, x0 + jitter(span), y0 + jitter(span), 1'b0);
        if ($urandom_range(1)) queue_req(REQ_RELEASE, b2, x0 + jitter(span), y0 + jitter(span), 1'b0);
    endtask

    task automatic queue_noise();
        queue_req(2'($urandom_range(3)), $urandom_range(3), $urandom_range(CMAX),
                  $urandom_range(CMAX), 1'($urandom_range(1)));
    endtask

    task automatic random_phase(int n_items, int span);
        int start_cnt;
        start_cnt = queued_cnt;
        while (queued_cnt - start_cnt < n_items) begin
            if ($urandom_range(4) == 0) queue_noise();
            else queue_gesture(span);
        end
    endtask

    initial begin
        s_valid      = 1'b0;
        s_req_type   = REQ_PRESS;
        s_button     = '0;
        s_pos_x      = '0;
        s_pos_y      = '0;
        s_scroll_dir = 1'b0;
        m_ready      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = CFG_DRAG_RX;
        cfg_wr_data  = '0;
        queued_cnt   = 0;
        accepted_cnt = 0;
        event_cnt    = 0;
        error_cnt    = 0;
        cycle_cnt    = 0;
        drag_rx = 16; drag_ry = 16; click_rx = 4; click_ry = 4;
        limit_x = CMAX; limit_y = CMAX;
        ev_mask = '0;
        motion_done = '0;
        for (int i = 0; i < NBTN; i++) begin
            has_start[i] = 1'b0; start_x[i] = 0; start_y[i] = 0; is_held[i] = 1'b0;
        end
        @(posedge aresetn);

        // Reset settings: everything masked, no events
        queue_req(REQ_PRESS, 0, 100, 100, 1'b0);
        queue_req(REQ_SCROLL, 0, 0, 0, 1'b1);
        queue_req(REQ_RELEASE, 0, 100, 100, 1'b0);

        // Directed: all enables on, default radii; zero radius writes are dropped
        write_all(16, 16, 4, 4, CMAX, CMAX, {MASK_W{1'b1}});
        write_register(CFG_DRAG_RX, '0);
        write_register(CFG_CLICK_RY, '0);
        queue_req(REQ_MOVE, 0, 0, 0, 1'b0);                 // point at the origin
        queue_req(REQ_MOVE, 0, CMAX, CMAX, 1'b0);           // not below the limit
        queue_req(REQ_SCROLL, 0, 5, 5, 1'b0);
        queue_req(REQ_SCROLL, 3, 5, 5, 1'b1);
        queue_req(REQ_PRESS, 3, 50, 50, 1'b0);              // unknown button
        queue_req(REQ_RELEASE, 3, 50, 50, 1'b0);
        queue_req(REQ_RELEASE, 1, 50, 50, 1'b0);            // release without a press
        queue_req(REQ_PRESS, 0, 1000, 1000, 1'b0);
        queue_req(REQ_PRESS, 0, 1002, 1001, 1'b0);          // press while started
        queue_req(REQ_MOVE, 0, 1001, 1001, 1'b0);
        queue_req(REQ_MOVE, 0, 900, 1000, 1'b0);            // drag
        queue_req(REQ_RELEASE, 0, 1000, 1000, 1'b0);        // click
        queue_req(REQ_PRESS, 0, 2000, 2000, 1'b0);
        queue_req(REQ_PRESS, 2, 2001, 2000, 1'b0);
        queue_req(REQ_RELEASE, 2, 2000, 2000, 1'b0);        // chord, left first
        queue_req(REQ_PRESS, 2, 3000, 3000, 1'b0);
        queue_req(REQ_PRESS, 0, 3000, 3001, 1'b0);
        queue_req(REQ_RELEASE, 0, 3000, 3000, 1'b0);        // chord, right first
        queue_req(REQ_RELEASE, 2, 3000, 3000, 1'b0);

        // Directional motions: drags off, so left/right/up/down fire one-shot
        write_all(16, 16, 4, 4, CMAX, CMAX, {MASK_W{1'b1}} & ~29'h010101);
        queue_req(REQ_PRESS, 1, 8000, 8000, 1'b0);
        queue_req(REQ_MOVE, 0, 7980, 8000, 1'b0);
        queue_req(REQ_MOVE, 0, 8030, 8000, 1'b0);
        queue_req(REQ_MOVE, 0, 8000, 7970, 1'b0);
        queue_req(REQ_MOVE, 0, 8000, 8040, 1'b0);
        queue_req(REQ_RELEASE, 1, 8001, 8001, 1'b0);

        // Random phases, extremes of the settings included
        write_all(1, 1, 1, 1, 0, 0, 29'($urandom() | 32'h1000000));
        random_phase(30, 8);
        write_all(4095, 4095, 4095, 4095, CMAX, CMAX, {MASK_W{1'b1}} & ~29'h010101);
        random_phase(30, 5000);
        write_all(16, 16, 4, 4, 8000, 8000, {MASK_W{1'b1}} & ~29'h010101);
        random_phase(30, 40);
        write_all($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 16),
                  $urandom_range(1, 16), $urandom_range(CMAX), $urandom_range(CMAX),
                  29'($urandom()));
        random_phase(30, 60);
        write_all(12, 20, 3, 6, CMAX, CMAX, {MASK_W{1'b1}});
        random_phase(30, 40);

        drain();
        $display("Checked %0d result beats from %0d pointer requests", event_cnt, accepted_cnt);
        $display("under the reset settings and seven register settings, extremes included.");
        if (error_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5ms;
        $display("Timed out with %0d events outstanding", expected_events.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mgr_pkg.sv
rtl/core/mgr_dist.sv
rtl/core/mgr_rbuf.sv
rtl/core/mouse_gesture_recognizer.sv
bench/mouse_gesture_recognizer_test.sv
